FILE: hdl/pddf_pkg.sv
// Shared types and constants for the pointing drift dead-zone filter.
`timescale 1ns / 1ps

package pddf_pkg;

    localparam int MOVE_W   = 16;
    localparam int OFF_W    = 24;
    localparam int DZ_W     = 15;
    localparam int SHIFT_W  = 4;
    localparam int IVAL_W   = 16;
    localparam int BTN_W    = 8;
    localparam int REP_W    = 3;
    localparam int STAMP_W  = 32;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int IN_DW    = 72;
    localparam int OUT_DW   = 56;

    localparam logic [DZ_W-1:0]    NOISE_BAND_RST = 15'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_RST      = 4'd4;
    localparam logic [IVAL_W-1:0]  SLOW_RST       = 16'd125;
    localparam logic [IVAL_W-1:0]  FAST_RST       = 16'd5;
    localparam logic [IVAL_W-1:0]  IDLE_RST       = 16'd1500;
    localparam logic [IVAL_W-1:0]  RETRY_RST      = 16'd250;

    typedef enum logic [CFG_AW-1:0] {
        CFG_NOISE_BAND = 3'd0,
        CFG_SHIFT      = 3'd1,
        CFG_SLOW       = 3'd2,
        CFG_FAST       = 3'd3,
        CFG_IDLE       = 3'd4,
        CFG_RETRY      = 3'd5
    } cfg_idx_t;

    // Per-axis filter results handed back to the top level.
    typedef struct packed {
        logic [OFF_W-1:0]         offset_next;
        logic [MOVE_W-1:0]        move;
    } axis_res_t;

endpackage

FILE: hdl/pddf_axis.sv
// One axis of drift compensation, IIR offset step and dead-zone gate.
`timescale 1ns / 1ps

module pddf_axis
(
    input  logic [pddf_pkg::MOVE_W-1:0]  raw,
    input  logic [pddf_pkg::OFF_W-1:0]   offset,
    input  logic [pddf_pkg::DZ_W-1:0]    noise_band,
    input  logic [pddf_pkg::SHIFT_W-1:0] step_shift,
    input  logic                         upd_en,
    output logic                         quiet_pre,
    output pddf_pkg::axis_res_t          res
);
    import pddf_pkg::*;

    // Subtract the offset rounded to nearest (floor of offset plus one half).
    function automatic logic [MOVE_W-1:0] compensate(input logic [MOVE_W-1:0] r,
                                                     input logic [OFF_W-1:0] off);
        logic [OFF_W:0] t;
        t = {off[OFF_W-1], off} + (OFF_W+1)'(128);
        return r - t[MOVE_W+7:8];
    endfunction

    // Magnitude strictly below the dead zone; full scale reads as 32768.
    function automatic logic in_zone(input logic [MOVE_W-1:0] v,
                                     input logic [DZ_W-1:0] dz);
        logic [MOVE_W-1:0] mag;
        mag = v[MOVE_W-1] ? (~v + 1'b1) : v;
        return mag < {1'b0, dz};
    endfunction

    logic [MOVE_W-1:0]        comp_pre;
    logic [MOVE_W-1:0]        comp_post;
    logic [MOVE_W-1:0]        comp_fin;
    logic signed [OFF_W:0]    diff;
    logic signed [OFF_W:0]    step;
    logic [OFF_W-1:0]         off_upd;

    always_comb
    begin
        comp_pre  = compensate(raw, offset);
        // Step toward raw*256 by diff/2^shift, rounded toward minus infinity.
        diff      = $signed({raw[MOVE_W-1], raw, 8'h00}) - $signed({offset[OFF_W-1], offset});
        step      = diff >>> step_shift;
        off_upd   = offset + step[OFF_W-1:0];
        comp_post = compensate(raw, off_upd);
        comp_fin  = upd_en ? comp_post : comp_pre;

        quiet_pre       = in_zone(comp_pre, noise_band);
        res.offset_next = upd_en ? off_upd : offset;
        res.move        = in_zone(comp_fin, noise_band) ? '0 : comp_fin;
    end

endmodule

FILE: hdl/pointing_drift_deadzone_filter_top.sv
// Top level of the pointing drift dead-zone filter with stream ports.
`timescale 1ns / 1ps
// A request is held in the input register and then in the result register before it
// is offered on m_tvalid; a stalled receiver can keep it in either stage.
// Throughput: one request per cycle unless m_tready stalls; the offsets, buttons, mode and
// motion stamp update in the same cycle that moves a non-failed read into the result.
// Reset: rst_n clears the valid flags of both stages and the filter state, and loads every
// configuration register with its default (dead zone 20, shift 4, 125/5/1500/250 ms).

module pointing_drift_deadzone_filter_top
#(
    parameter int BUTTON_COUNT = 3,
    parameter int TIME_BITS    = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // raw_x[15:0], raw_y[31:16], button_byte[39:32], time_ms[71:40]
    input  logic [pddf_pkg::IN_DW-1:0]     s_tdata,
    // read_error[0]
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // move_x[15:0], move_y[31:16], motion_seen[32], button_edges[35:33],
    // button_levels[38:36], next_interval_ms[54:39], zero pad[55]
    output logic [pddf_pkg::OUT_DW-1:0]    m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [pddf_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [pddf_pkg::CFG_DW-1:0]    cfg_wdata
);
    import pddf_pkg::*;

    // Only the low buttons, and at most three, are reported.
    localparam logic [REP_W-1:0] BTN_MASK =
        (BUTTON_COUNT >= REP_W) ? {REP_W{1'b1}} : REP_W'((1 << BUTTON_COUNT) - 1);

    // Configuration registers.
    logic [DZ_W-1:0]    noise_band_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [IVAL_W-1:0]  slow_reg;
    logic [IVAL_W-1:0]  fast_reg;
    logic [IVAL_W-1:0]  idle_reg;
    logic [IVAL_W-1:0]  retry_reg;

    // Input stage.
    logic                 in_valid_reg;
    logic [MOVE_W-1:0]    in_x_reg;
    logic [MOVE_W-1:0]    in_y_reg;
    logic [BTN_W-1:0]     in_btn_reg;
    logic [TIME_BITS-1:0] in_now_reg;
    logic                 in_err_reg;

    // Filter state.
    logic [OFF_W-1:0]     x_off_reg,  x_off_next;
    logic [OFF_W-1:0]     y_off_reg,  y_off_next;
    logic [BTN_W-1:0]     last_btn_reg;
    logic                 fast_mode_reg, fast_mode_next;
    logic [TIME_BITS-1:0] last_motion_reg, last_motion_next;

    // Result stage.
    logic                 out_valid_reg;
    logic [OUT_DW-1:0]    out_data_reg, out_data_next;

    logic                 advance;
    logic                 upd_en;
    logic                 moved;
    logic [TIME_BITS-1:0] elapsed;
    logic [IVAL_W-1:0]    ival_sel;
    logic [IVAL_W-1:0]    ival;
    logic [REP_W-1:0]     edges;
    logic [REP_W-1:0]     levels;
    logic                 x_quiet;
    logic                 y_quiet;
    axis_res_t            x_res;
    axis_res_t            y_res;

    // Move the input register into the result register whenever the result slot
    // is free or is being taken; accept a new request into a free or draining stage.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_band_reg <= NOISE_BAND_RST;
            shift_reg      <= SHIFT_RST;
            slow_reg       <= SLOW_RST;
            fast_reg       <= FAST_RST;
            idle_reg       <= IDLE_RST;
            retry_reg      <= RETRY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_NOISE_BAND: noise_band_reg <= cfg_wdata[DZ_W-1:0];
                CFG_SHIFT:      shift_reg      <= cfg_wdata[SHIFT_W-1:0];
                CFG_SLOW:       slow_reg       <= cfg_wdata;
                CFG_FAST:       fast_reg       <= cfg_wdata;
                CFG_IDLE:       idle_reg       <= cfg_wdata;
                CFG_RETRY:      retry_reg      <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // Input stage payload; the timestamp is taken modulo 2^TIME_BITS.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_x_reg   <= s_tdata[15:0];
            in_y_reg   <= s_tdata[31:16];
            in_btn_reg <= s_tdata[39:32];
            in_now_reg <= TIME_BITS'(s_tdata[71:40]);
            in_err_reg <= s_tuser;
        end
    end

    // Drift gate: slow mode, no button bit at all and both axes quiet.
    assign upd_en = !fast_mode_reg && (in_btn_reg == '0) && x_quiet && y_quiet;

    pddf_axis u_axis_x
    (
        .raw        (in_x_reg),
        .offset     (x_off_reg),
        .noise_band (noise_band_reg),
        .step_shift (shift_reg),
        .upd_en     (upd_en),
        .quiet_pre  (x_quiet),
        .res        (x_res)
    );

    pddf_axis u_axis_y
    (
        .raw        (in_y_reg),
        .offset     (y_off_reg),
        .noise_band (noise_band_reg),
        .step_shift (shift_reg),
        .upd_en     (upd_en),
        .quiet_pre  (y_quiet),
        .res        (y_res)
    );

    always_comb
    begin
        moved   = (x_res.move != '0) || (y_res.move != '0);
        elapsed = in_now_reg - last_motion_reg;

        // Motion enters fast mode; a long quiet spell drops back to slow.
        if (moved)
            fast_mode_next = 1'b1;
        else if (fast_mode_reg && (elapsed > TIME_BITS'(idle_reg)))
            fast_mode_next = 1'b0;
        else
            fast_mode_next = fast_mode_reg;

        last_motion_next = moved ? in_now_reg : last_motion_reg;
        x_off_next       = x_res.offset_next;
        y_off_next       = y_res.offset_next;

        if (in_err_reg)
            ival_sel = retry_reg;
        else if (fast_mode_next)
            ival_sel = fast_reg;
        else
            ival_sel = slow_reg;
        // An interval of zero is reported as one.
        ival = (ival_sel == '0) ? IVAL_W'(1) : ival_sel;

        if (in_err_reg)
        begin
            edges         = '0;
            levels        = last_btn_reg[REP_W-1:0] & BTN_MASK;
            out_data_next = {1'b0, ival, levels, edges, 1'b0, {MOVE_W{1'b0}}, {MOVE_W{1'b0}}};
        end
        else
        begin
            edges         = (in_btn_reg[REP_W-1:0] ^ last_btn_reg[REP_W-1:0]) & BTN_MASK;
            levels        = in_btn_reg[REP_W-1:0] & BTN_MASK;
            out_data_next = {1'b0, ival, levels, edges, moved, y_res.move, x_res.move};
        end
    end

    // Filter state: a failed read leaves all of it untouched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg       <= '0;
            y_off_reg       <= '0;
            last_btn_reg    <= '0;
            fast_mode_reg   <= 1'b0;
            last_motion_reg <= '0;
        end
        else if (advance && !in_err_reg)
        begin
            x_off_reg       <= x_off_next;
            y_off_reg       <= y_off_next;
            last_btn_reg    <= in_btn_reg;
            fast_mode_reg   <= fast_mode_next;
            last_motion_reg <= last_motion_next;
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

    // A failed read must leave the drift offsets and mode alone.
    a_err_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_err_reg) |=>
            ($stable(x_off_reg) && $stable(y_off_reg) && $stable(fast_mode_reg)))
        else $error("filter state changed on a failed read");

    // Reported motion arms fast mode and stamps the motion time.
    a_motion_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_err_reg && moved) |=>
            (fast_mode_reg && (last_motion_reg == $past(in_now_reg))))
        else $error("motion did not select fast mode");

    // Back-pressure reaches the input only when both stages are full and stalled.
    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    // The drift offsets only move in slow mode.
    a_drift_slow_only: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fast_mode_reg) |=> ($stable(x_off_reg) && $stable(y_off_reg)))
        else $error("drift offset updated in fast mode");

endmodule

FILE: tb/sv/pointing_drift_deadzone_filter_top_tb.sv
// Self-checking testbench for the pointing drift dead-zone filter top level.
`timescale 1ns / 1ps

module pointing_drift_deadzone_filter_top_tb;

    import pddf_pkg::*;

    // Indexes past the last register: writes to them must be ignored.
    localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

    // A request passes the input register and then the result register before m_tvalid.
    localparam int DRAIN_CYCLES = 8;
    // Watchdog cap on the whole run, far above what the slowest correct run needs.
    localparam int CYCLE_LIMIT  = 300000;
    // Long receiver hold-off, long enough to fill the pipe and stall the input.
    localparam int HOLD_OFF_CYCLES = 300;

    // One sensor poll as it enters the block.
    typedef struct {
        logic signed [MOVE_W-1:0] raw_x;
        logic signed [MOVE_W-1:0] raw_y;
        logic [BTN_W-1:0]         buttons;
        logic [STAMP_W-1:0]       stamp;
        logic                     read_error;
    } poll_req_t;

    // One report as it leaves the block.
    typedef struct {
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
        logic                     motion_seen;
        logic [REP_W-1:0]         edges;
        logic [REP_W-1:0]         levels;
        logic [IVAL_W-1:0]        interval;
    } poll_rep_t;

    // Drift filter predictor plus the queue of reports it still owes.
    class drift_scoreboard;
        logic [DZ_W-1:0]          noise_band;
        logic [SHIFT_W-1:0]       shift;
        logic [IVAL_W-1:0]        slow_ival;
        logic [IVAL_W-1:0]        fast_ival;
        logic [IVAL_W-1:0]        idle_ms;
        logic [IVAL_W-1:0]        retry_ival;

        logic signed [OFF_W-1:0]  x_off;
        logic signed [OFF_W-1:0]  y_off;
        logic [BTN_W-1:0]         last_btn;
        logic                     fast_mode;
        logic [STAMP_W-1:0]       last_move_ms;

        poll_rep_t                owed_q[$];
        int                       errors;

        function new();
            noise_band   = NOISE_BAND_RST;
            shift        = SHIFT_RST;
            slow_ival    = SLOW_RST;
            fast_ival    = FAST_RST;
            idle_ms      = IDLE_RST;
            retry_ival   = RETRY_RST;
            x_off        = '0;
            y_off        = '0;
            last_btn     = '0;
            fast_mode    = 1'b0;
            last_move_ms = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_NOISE_BAND: noise_band = val[DZ_W-1:0];
                CFG_SHIFT:      shift      = val[SHIFT_W-1:0];
                CFG_SLOW:       slow_ival  = val;
                CFG_FAST:       fast_ival  = val;
                CFG_IDLE:       idle_ms    = val;
                CFG_RETRY:      retry_ival = val;
                default:        ;
            endcase
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Raw minus the offset rounded to the nearest integer, wrapped to 16 bits.
        function logic signed [MOVE_W-1:0] compensate(logic signed [MOVE_W-1:0] raw,
                                                      logic signed [OFF_W-1:0] off);
            int t;
            t = int'(off) + 128;
            return MOVE_W'(int'(raw) - (t >>> 8));
        endfunction

        function int magnitude(logic signed [MOVE_W-1:0] v);
            return (v < 0) ? -int'(v) : int'(v);
        endfunction

        // Floor division by a power of two is an arithmetic shift.
        function logic signed [OFF_W-1:0] drift_step(logic signed [OFF_W-1:0] off,
                                                     logic signed [MOVE_W-1:0] raw);
            int diff;
            diff = int'(raw) * 256 - int'(off);
            return OFF_W'(int'(off) + (diff >>> shift));
        endfunction

        function logic [IVAL_W-1:0] nonzero(logic [IVAL_W-1:0] v);
            return (v == 0) ? IVAL_W'(1) : v;
        endfunction

        function void note_request(poll_req_t r);
            poll_rep_t                e;
            logic signed [MOVE_W-1:0] cx;
            logic signed [MOVE_W-1:0] cy;
            logic [BTN_W-1:0]         flips;
            logic [STAMP_W-1:0]       elapsed;
            int                       dz;
            e = '{default: 0};
            if (r.read_error)
            begin
                e.levels   = last_btn[REP_W-1:0];
                e.interval = nonzero(retry_ival);
                owed_q.push_back(e);
                return;
            end
            dz = int'(noise_band);
            cx = compensate(r.raw_x, x_off);
            cy = compensate(r.raw_y, y_off);
            if (!fast_mode && r.buttons == 0 && magnitude(cx) < dz && magnitude(cy) < dz)
            begin
                x_off = drift_step(x_off, r.raw_x);
                y_off = drift_step(y_off, r.raw_y);
                cx    = compensate(r.raw_x, x_off);
                cy    = compensate(r.raw_y, y_off);
            end
            e.move_x      = (magnitude(cx) >= dz) ? cx : '0;
            e.move_y      = (magnitude(cy) >= dz) ? cy : '0;
            e.motion_seen = (e.move_x != 0) || (e.move_y != 0);
            flips         = r.buttons ^ last_btn;
            e.edges       = flips[REP_W-1:0];
            e.levels      = r.buttons[REP_W-1:0];
            last_btn      = r.buttons;
            elapsed       = r.stamp - last_move_ms;
            if (e.motion_seen)
            begin
                fast_mode    = 1'b1;
                last_move_ms = r.stamp;
            end
            else if (fast_mode && elapsed > STAMP_W'(idle_ms))
                fast_mode = 1'b0;
            e.interval = nonzero(fast_mode ? fast_ival : slow_ival);
            owed_q.push_back(e);
        endfunction

        function void check_field(string name, longint expv, longint actv);
            if (expv != actv)
            begin
                $error("%s expected %0d got %0d", name, expv, actv);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DW-1:0] d);
            poll_rep_t e;
            if (owed_q.size() == 0)
            begin
                $error("report with no request waiting: %h", d);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            check_field("move_x", e.move_x, $signed(d[15:0]));
            check_field("move_y", e.move_y, $signed(d[31:16]));
            check_field("motion_seen", e.motion_seen, d[32]);
            check_field("button_edges", e.edges, d[35:33]);
            check_field("button_levels", e.levels, d[38:36]);
            check_field("next_interval_ms", e.interval, d[54:39]);
            check_field("pad", 0, d[55]);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic [IN_DW-1:0]     s_tdata;
    logic                 s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [OUT_DW-1:0]    m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_we;
    logic [CFG_AW-1:0]    cfg_addr;
    logic [CFG_DW-1:0]    cfg_wdata;

    drift_scoreboard      sb = new();

    // Flags shared by stimulus and receiver, then the stimulus clock and watchdog count.
    bit                   idling_on;
    bit                   hold_off_req;
    logic [STAMP_W-1:0]   now_ms;
    int                   cycle_count;

    pointing_drift_deadzone_filter_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: a hung handshake or a lost report ends here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Check every report the moment it is taken. All drives are nonblocking,
    // so the values read here are the ones the block saw at this edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Receiver: ready in random stretches with random stall bursts, and one
    // long hold-off on request so the pipe fills and backs up into s_tready.
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Offer one request and hold it until taken; s_tvalid stays high between
    // requests unless idling_on inserts a random gap, so they can go back to back.
    task automatic send_poll(logic signed [MOVE_W-1:0] rx, logic signed [MOVE_W-1:0] ry,
                             logic [BTN_W-1:0] btn, logic [STAMP_W-1:0] stamp,
                             logic err);
        poll_req_t req;
        req = '{raw_x: rx, raw_y: ry, buttons: btn, stamp: stamp, read_error: err};
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, btn, ry, rx};
        s_tuser  <= err;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(req);
    endtask

    // Wait for every owed report, then let the pipe settle before any write.
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Load all six registers, plus junk into the unused indexes.
    task automatic configure(logic [CFG_DW-1:0] dz, logic [CFG_DW-1:0] sh,
                             logic [CFG_DW-1:0] slow, logic [CFG_DW-1:0] fast,
                             logic [CFG_DW-1:0] idle, logic [CFG_DW-1:0] retry);
        write_reg(CFG_NOISE_BAND, dz);
        write_reg(CFG_SHIFT, sh);
        write_reg(CFG_SLOW, slow);
        write_reg(CFG_FAST, fast);
        write_reg(CFG_IDLE, idle);
        write_reg(CFG_RETRY, retry);
        write_reg(CFG_SPARE_LO, CFG_DW'($urandom()));
        write_reg(CFG_SPARE_HI, CFG_DW'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_random(bit full_range);
        if (full_range)
            configure(CFG_DW'($urandom()), CFG_DW'($urandom()), CFG_DW'($urandom()),
                      CFG_DW'($urandom()), CFG_DW'($urandom()), CFG_DW'($urandom()));
        else
            configure(CFG_DW'($urandom_range(1, 120)), CFG_DW'($urandom_range(0, 15)),
                      CFG_DW'($urandom_range(1, 65535)), CFG_DW'($urandom_range(1, 65535)),
                      CFG_DW'($urandom_range(0, 3000)), CFG_DW'($urandom_range(1, 65535)));
    endtask

    // Mostly sensor noise around a slow bias (what the drift filter tracks),
    // some real strokes past the dead zone, some arbitrary words.
    function automatic logic [MOVE_W-1:0] pick_axis(int bias, int dz);
        int pick;
        int span;
        int v;
        pick = $urandom_range(0, 99);
        span = ((dz > 64) ? 64 : dz) + 2;
        if (pick < 70)
            v = bias + int'($urandom_range(0, 2 * span)) - span;
        else if (pick < 85)
            v = bias + ($urandom_range(0, 1) ? 1 : -1) * (dz + int'($urandom_range(0, 400)));
        else
            v = int'($urandom());
        return MOVE_W'(v);
    endfunction

    task automatic run_random(int count, bit with_hold_off);
        int               bias_x;
        int               bias_y;
        int               dz;
        int               pick;
        logic [BTN_W-1:0] btn;
        bias_x = int'($urandom_range(0, 400)) - 200;
        bias_y = int'($urandom_range(0, 400)) - 200;
        dz     = int'(sb.noise_band);
        for (int i = 0; i < count; i++)
        begin
            if (with_hold_off && i == 20)
                hold_off_req = 1'b1;
            // Advance the clock: small steps keep fast mode alive, jumps let it time out.
            case ($urandom_range(0, 9))
                0:       now_ms = STAMP_W'($urandom());
                1, 2:    now_ms += $urandom_range(0, 2 * int'(sb.idle_ms) + 10);
                default: now_ms += $urandom_range(0, 40);
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 70)
                btn = '0;
            else if (pick < 85)
                btn = BTN_W'($urandom_range(0, 7));
            else
                btn = BTN_W'($urandom_range(0, 255));
            send_poll(pick_axis(bias_x, dz), pick_axis(bias_y, dz), btn, now_ms,
                      $urandom_range(0, 99) < 6);
        end
        s_tvalid <= 1'b0;
    endtask

    // Directed polls at the reset settings (dead zone 20, shift 4).
    task automatic directed_polls();
        // Quiet polls in slow mode: the drift filter steps.
        send_poll(16'sd0, 16'sd0, 8'h00, 32'd1000, 1'b0);
        send_poll(16'sd5, -16'sd7, 8'h00, 32'd1010, 1'b0);
        send_poll(16'sd19, -16'sd19, 8'h00, 32'd1012, 1'b0);
        send_poll(16'sd20, 16'sd0, 8'h00, 32'd1014, 1'b0);
        // Full-scale values: -32768 counts as magnitude 32768.
        send_poll(16'sd32767, -16'sd32768, 8'h00, 32'd1020, 1'b0);
        send_poll(-16'sd32768, 16'sd32767, 8'h00, 32'd1022, 1'b0);
        // Buttons: reported bits, then only the unreported high bits.
        send_poll(16'sd0, 16'sd0, 8'h01, 32'd1030, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'h07, 32'd1031, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'hF8, 32'd1032, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'hFF, 32'd1033, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'h00, 32'd1034, 1'b0);
        // Failed reads: nothing moves, retry interval comes back.
        send_poll(16'sd1234, -16'sd1234, 8'h55, 32'd1040, 1'b1);
        send_poll(-16'sd1, -16'sd1, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        // Motion just before the timestamp wraps, then idle across the wrap:
        // exactly the timeout keeps fast mode, one more ms drops it.
        send_poll(16'sd500, 16'sd500, 8'h00, 32'hFFFF_FFF0, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'h00, 32'h0000_0100, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'h00, 32'h0000_05CC, 1'b0);
        send_poll(16'sd0, 16'sd0, 8'h00, 32'h0000_05CD, 1'b0);
        // Steady bias in slow mode: the offsets creep toward it.
        repeat (4) send_poll(16'sd15, 16'sd15, 8'h00, 32'h0000_0600, 1'b0);
        repeat (2) send_poll(-16'sd15, -16'sd15, 8'h00, 32'h0000_0610, 1'b0);
        s_tvalid <= 1'b0;
        now_ms = 32'h0000_1000;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        idling_on    = 1'b1;
        hold_off_req = 1'b0;
        now_ms       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_polls();
        wait_drained();

        // All ones: every register masks down to the top of its range.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(60, 1'b0);
        wait_drained();

        // All zeros: no drift, any nonzero value is motion, intervals read as one.
        configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(60, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            configure_random(phase == 3);
            run_random(100, phase == 0);
            wait_drained();
        end

        // Closing stretch at full rate: no gaps on either side.
        idling_on = 1'b0;
        configure_random(1'b0);
        run_random(100, 1'b0);
        wait_drained();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
